[hw/rtl/mlpd_pkg.sv]
// Shared types and constants for the marker/length packet deframer.
// No dependencies; mlpd_ctrl, mlpd_datapath and the top level import it.
`timescale 1ns / 1ps

package mlpd_pkg;

  // Frame layout and processing limits
  localparam int unsigned MIN_BUFFERED = 5;
  localparam int unsigned MAX_RESULTS  = 64;
  localparam int unsigned CNT_W        = 7;   // holds 0..MAX_RESULTS
  localparam int unsigned OFF_W        = 9;   // read offset, up to length + 3

  // Configuration register indexes and reset values
  localparam logic [7:0] REG_START_MARKER = 8'd0;
  localparam logic [7:0] REG_END_MARKER   = 8'd1;
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] END_MARKER_RST   = 8'h55;

  // Frame type codes and result classes
  localparam logic [7:0] TYPE_CYCLE_TIME  = 8'd1;
  localparam logic [7:0] TYPE_PARTS_COUNT = 8'd2;
  localparam logic [1:0] CLASS_CYCLE_TIME  = 2'd0;
  localparam logic [1:0] CLASS_PARTS_COUNT = 2'd1;
  localparam logic [1:0] CLASS_UNKNOWN     = 2'd2;

  // Read offset selection, relative to the oldest buffered byte
  localparam logic [2:0] OFF_ZERO = 3'd0;  // candidate start marker
  localparam logic [2:0] OFF_ONE  = 3'd1;  // type byte
  localparam logic [2:0] OFF_TWO  = 3'd2;  // length byte
  localparam logic [2:0] OFF_ENDM = 3'd3;  // end marker, length + 3
  localparam logic [2:0] OFF_VAL  = 3'd4;  // payload byte 3 + val_idx

  typedef struct packed {
    logic       push;         // store the accepted byte
    logic       rd_en;        // read the byte store
    logic [2:0] rd_sel;       // which offset to read
    logic [1:0] val_idx;      // payload byte index for OFF_VAL
    logic       drop_one;     // discard the oldest byte
    logic       latch_type;
    logic       latch_len;
    logic       shift_value;  // shift read data into the value
    logic       clear_value;
    logic       emit;         // retire pending result, stage new one, drop frame
    logic       flush;        // send pending result as last of this item
  } mlpd_cmd_t;

  typedef struct packed {
    logic fill_lt_min;   // fewer than five bytes buffered
    logic fill_is_one;
    logic data_is_start; // read data equals start marker
    logic data_is_end;   // read data equals end marker
    logic fill_lt_size;  // read data as length: frame not complete yet
    logic len_short;     // latched length under four
    logic pend_valid;
    logic out_busy;      // output register full and not taken this cycle
  } mlpd_status_t;

endpackage

[hw/rtl/mlpd_if.sv]
// Handshake channel interfaces for the deframer: received bytes, frame
// results and configuration writes. No dependencies.
`timescale 1ns / 1ps

interface mlpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mlpd_frame_if;
  logic               valid;
  logic               ready;
  logic [7:0]         frame_type;
  logic [1:0]         frame_class;
  logic signed [31:0] frame_value;
  logic [7:0]         payload_length;
  logic               short_payload;
  logic               last_frame;
  modport source (output valid, output frame_type, output frame_class,
                  output frame_value, output payload_length,
                  output short_payload, output last_frame, input ready);
  modport sink   (input valid, input frame_type, input frame_class,
                  input frame_value, input payload_length,
                  input short_payload, input last_frame, output ready);
endinterface

interface mlpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mlpd_datapath.sv]
// Deframer datapath: circular byte store, head/fill pointers, frame fields,
// pending result and output register. Depends on mlpd_pkg.
`timescale 1ns / 1ps

module mlpd_datapath import mlpd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  mlpd_cmd_t          cmd,
  output mlpd_status_t       status,
  input  logic [7:0]         rx_byte,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_type,
  output logic [1:0]         out_class,
  output logic signed [31:0] out_value,
  output logic [7:0]         out_len,
  output logic               out_short,
  output logic               out_last
);

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam int unsigned FW = $clog2(STORE_DEPTH + 1);
  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(STORE_DEPTH);

  logic [7:0]    mem [STORE_DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] head;
  logic [FW-1:0] fill;
  logic [7:0]    start_marker;
  logic [7:0]    end_marker;

  logic [7:0]  frm_type;
  logic [7:0]  frm_len;
  logic [31:0] value;

  logic               pend_valid;
  logic [7:0]         pend_type;
  logic [1:0]         pend_class;
  logic signed [31:0] pend_value;
  logic [7:0]         pend_len;
  logic               pend_short;

  logic [OFF_W-1:0] rd_off;
  logic [OFF_W-1:0] frame_size;
  logic [OFF_W-1:0] drop_cnt;
  logic [AW:0]      rd_sum;
  logic [AW-1:0]    rd_addr;
  logic [AW:0]      wr_sum;
  logic [AW-1:0]    wr_addr;
  logic [AW:0]      hd_sum;
  logic [AW-1:0]    head_next;
  logic             full;
  logic             out_load;
  logic [1:0]       new_class;

  // Read address: head plus offset, wrapped once
  always_comb begin
    unique case (cmd.rd_sel)
      OFF_ZERO: rd_off = OFF_W'(0);
      OFF_ONE:  rd_off = OFF_W'(1);
      OFF_TWO:  rd_off = OFF_W'(2);
      OFF_ENDM: rd_off = {1'b0, rd_data} + OFF_W'(3);
      OFF_VAL:  rd_off = OFF_W'(3) + OFF_W'(cmd.val_idx);
      default:  rd_off = OFF_W'(0);
    endcase
  end

  assign rd_sum  = {1'b0, head} + (AW + 1)'(rd_off);
  assign rd_addr = (rd_sum >= DEPTH_EXT) ? AW'(rd_sum - DEPTH_EXT) : AW'(rd_sum);
  assign wr_sum  = {1'b0, head} + (AW + 1)'(fill);
  assign wr_addr = (wr_sum >= DEPTH_EXT) ? AW'(wr_sum - DEPTH_EXT) : AW'(wr_sum);
  assign full    = (fill == FW'(STORE_DEPTH));

  assign frame_size = {1'b0, frm_len} + OFF_W'(4);
  always_comb begin
    priority if (cmd.emit) drop_cnt = frame_size;
    else if (cmd.drop_one || (cmd.push && full)) drop_cnt = OFF_W'(1);
    else drop_cnt = OFF_W'(0);
  end
  assign hd_sum    = {1'b0, head} + (AW + 1)'(drop_cnt);
  assign head_next = (hd_sum >= DEPTH_EXT) ? AW'(hd_sum - DEPTH_EXT) : AW'(hd_sum);

  always_ff @(posedge clk) begin
    if (cmd.push) mem[wr_addr] <= rx_byte;
    if (cmd.rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else begin
      head <= head_next;
      priority if (cmd.push) begin
        if (!full) fill <= fill + FW'(1);
      end else if (cmd.emit) begin
        fill <= fill - FW'(frame_size);
      end else if (cmd.drop_one) begin
        fill <= fill - FW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_START_MARKER) start_marker <= cfg_data;
      if (cfg_index == REG_END_MARKER)   end_marker   <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_type) frm_type <= rd_data;
    if (cmd.latch_len)  frm_len  <= rd_data;
    if (cmd.clear_value) value <= '0;
    else if (cmd.shift_value) value <= {value[23:0], rd_data};
  end

  always_comb begin
    unique case (frm_type)
      TYPE_CYCLE_TIME:  new_class = CLASS_CYCLE_TIME;
      TYPE_PARTS_COUNT: new_class = CLASS_PARTS_COUNT;
      default:          new_class = CLASS_UNKNOWN;
    endcase
  end

  // Pending result: held back until we know whether another follows
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.emit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pend_type  <= frm_type;
      pend_class <= new_class;
      pend_value <= value;
      pend_len   <= frm_len;
      pend_short <= (frm_len < 8'd4);
    end
  end

  assign out_load = cmd.flush || (cmd.emit && pend_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_type  <= pend_type;
      out_class <= pend_class;
      out_value <= pend_value;
      out_len   <= pend_len;
      out_short <= pend_short;
      out_last  <= cmd.flush;
    end
  end

  always_comb begin
    status.fill_lt_min   = (fill < FW'(MIN_BUFFERED));
    status.fill_is_one   = (fill == FW'(1));
    status.data_is_start = (rd_data == start_marker);
    status.data_is_end   = (rd_data == end_marker);
    status.fill_lt_size  = (fill < (FW'(rd_data) + FW'(4)));
    status.len_short     = (frm_len < 8'd4);
    status.pend_valid    = pend_valid;
    status.out_busy      = out_valid && !out_ready;
  end

endmodule

[hw/rtl/mlpd_ctrl.sv]
// Deframer controller: sequences store reads, marker scan, frame checks and
// result hand-off. Depends on mlpd_pkg.
`timescale 1ns / 1ps

module mlpd_ctrl import mlpd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mlpd_status_t status,
  output mlpd_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TOP  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_TYPE = 4'd3;
  localparam logic [3:0] S_LEN  = 4'd4;
  localparam logic [3:0] S_ENDM = 4'd5;
  localparam logic [3:0] S_VAL  = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;
  localparam logic [3:0] S_END  = 4'd8;

  logic [3:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [1:0]       vcnt, vcnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      vcnt  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      vcnt  <= vcnt_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    vcnt_next  = vcnt;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.push   = 1'b1;
          count_next = '0;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        if (status.fill_lt_min || count == CNT_W'(MAX_RESULTS)) begin
          state_next = S_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = OFF_ZERO;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.data_is_start) begin
          if (status.fill_lt_min) begin
            state_next = S_END;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = OFF_ONE;
            state_next = S_TYPE;
          end
        end else begin
          // drop the byte and look at the one behind it
          cmd.drop_one = 1'b1;
          if (status.fill_is_one) begin
            state_next = S_END;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = OFF_ONE;
          end
        end
      end
      S_TYPE: begin
        cmd.latch_type = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_sel     = OFF_TWO;
        state_next     = S_LEN;
      end
      S_LEN: begin
        cmd.latch_len = 1'b1;
        if (status.fill_lt_size) begin
          state_next = S_END;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = OFF_ENDM;
          state_next = S_ENDM;
        end
      end
      S_ENDM: begin
        if (!status.data_is_end) begin
          cmd.drop_one = 1'b1;
          state_next   = S_TOP;
        end else if (status.len_short) begin
          cmd.clear_value = 1'b1;
          state_next      = S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = OFF_VAL;
          cmd.val_idx = 2'd0;
          vcnt_next   = 2'd0;
          state_next  = S_VAL;
        end
      end
      S_VAL: begin
        cmd.shift_value = 1'b1;
        if (vcnt == 2'd3) begin
          state_next = S_EMIT;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = OFF_VAL;
          cmd.val_idx = vcnt + 2'd1;
          vcnt_next   = vcnt + 2'd1;
        end
      end
      S_EMIT: begin
        if (!(status.pend_valid && status.out_busy)) begin
          cmd.emit   = 1'b1;
          count_next = count + CNT_W'(1);
          state_next = S_TOP;
        end
      end
      S_END: begin
        if (!status.pend_valid) begin
          state_next = S_IDLE;
        end else if (!status.out_busy) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hw/rtl/marker_length_packet_deframer_top.sv]
// Top level of the marker/length packet deframer.
// Depends on mlpd_pkg, mlpd_if, mlpd_ctrl and mlpd_datapath.
//
// Usage:
//   rx  - received bytes, one item per byte (valid/ready).
//   tx  - frame results: type, class, big-endian value, length, short flag
//         and last_frame, which marks the final result caused by one byte.
//   cfg - register writes: index 0 start marker, index 1 end marker. Always
//         ready; write only while the block is idle.
// Frame: start marker, type, length L, L payload bytes, end marker.
// Flow: rx is ready only in the idle state. The scan reads the store through
// one registered port. A result is held one frame back so that last_frame is
// known. At most 64 results per byte.
// Stall: a full, untaken output register holds the sequencer; no result is
// ever dropped. Reset (rst, synchronous) empties the store, restores the
// markers to 0xAA / 0x55 and clears all pending results.
`timescale 1ns / 1ps

module marker_length_packet_deframer_top import mlpd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 512
) (
  input  logic   clk,
  input  logic   rst,
  mlpd_byte_if.sink    rx,
  mlpd_frame_if.source tx,
  mlpd_cfg_if.sink     cfg
);

  mlpd_cmd_t    cmd;
  mlpd_status_t status;

  // configuration writes are always taken and land in the next cycle
  assign cfg.ready = 1'b1;

  mlpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .status   (status),
    .cmd      (cmd)
  );

  mlpd_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .rx_byte   (rx.rx_byte),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_type  (tx.frame_type),
    .out_class (tx.frame_class),
    .out_value (tx.frame_value),
    .out_len   (tx.payload_length),
    .out_short (tx.short_payload),
    .out_last  (tx.last_frame)
  );

endmodule

[tb/tb.sv]
// Self-checking bench for marker_length_packet_deframer_top: random valid/ready
// traffic on rx and tx, cfg writes, and a behavioral deframer that predicts
// each result. Depends on mlpd_pkg, mlpd_if and the deframer RTL.
`timescale 1ns / 1ps

module tb import mlpd_pkg::*; ();

  // Margin after the block is idle and every expected result has arrived,
  // before a register write or the end of the run.
  localparam int SETTLE_CYCLES  = 4;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES    = 300;
  // Cycles with no handshake on any channel before the run is declared hung.
  // Slowest legal gap: the receiver hold-off plus a long source gap, or a
  // trailing rescan of a full window of bad headers; the limit sits several
  // times above that.
  localparam int WATCHDOG_LIMIT = 10000;

  // Zero-length frames piled up behind one blocking header
  localparam int         BURST_FRAMES  = 12;
  localparam logic [7:0] BURST_HDR_LEN = 8'(4 * BURST_FRAMES - 1);

  // Register indexes the block must ignore
  localparam logic [7:0] REG_SPARE = 8'd2;
  localparam logic [7:0] REG_TOP   = 8'hFF;

  typedef struct packed {
    logic [7:0]         frame_type;
    logic [1:0]         frame_class;
    logic signed [31:0] frame_value;
    logic [7:0]         payload_length;
    logic               short_payload;
    logic               last_frame;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;

  mlpd_byte_if  byte_ch ();
  mlpd_frame_if frame_ch ();
  mlpd_cfg_if   cfg_ch ();

  marker_length_packet_deframer_top #(
    .STORE_DEPTH(512)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rx (byte_ch),
    .tx (frame_ch),
    .cfg(cfg_ch)
  );

  always #2 clk = ~clk;

  // Predictor state: its own copy of the markers and of the buffered bytes
  logic [7:0]    start_mark;
  logic [7:0]    end_mark;
  logic [7:0]    byte_window[$];
  frame_result_t pending_frames[$];

  int errors;
  int bytes_sent;
  int frames_checked;
  int regs_written;
  int idle_cycles;

  bit src_gaps;   // source inserts random gaps between items
  bit sink_gaps;  // receiver drops ready at random
  bit hold_req;   // ask the receiver for one long hold-off

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Append one accepted byte and queue every frame result it causes.
  function automatic void deframe_byte(input logic [7:0] b);
    int            found;
    int            pos;
    int            fsize;
    logic [7:0]    len;
    frame_result_t res;
    byte_window.push_back(b);
    found = 0;
    while (byte_window.size() >= MIN_BUFFERED && found < MAX_RESULTS) begin
      // Skip to the first start marker; with none, the whole window goes.
      pos = 0;
      while (pos < byte_window.size() && byte_window[pos] != start_mark) pos++;
      if (pos == byte_window.size()) begin
        byte_window.delete();
        break;
      end
      repeat (pos) void'(byte_window.pop_front());
      if (byte_window.size() < MIN_BUFFERED) break;
      len   = byte_window[2];
      fsize = int'(len) + 4;
      if (byte_window.size() < fsize) break;
      // Bad closing byte: drop the candidate marker and rescan.
      if (byte_window[fsize - 1] != end_mark) begin
        void'(byte_window.pop_front());
        continue;
      end
      res.frame_type     = byte_window[1];
      res.frame_class    = (res.frame_type == TYPE_CYCLE_TIME)  ? CLASS_CYCLE_TIME :
                           (res.frame_type == TYPE_PARTS_COUNT) ? CLASS_PARTS_COUNT :
                                                                  CLASS_UNKNOWN;
      res.payload_length = len;
      res.short_payload  = (len < 8'd4);
      res.frame_value    = res.short_payload ? '0 :
                           {byte_window[3], byte_window[4], byte_window[5], byte_window[6]};
      res.last_frame     = 1'b0;
      pending_frames.push_back(res);
      found++;
      repeat (fsize) void'(byte_window.pop_front());
    end
    // Mark the final result caused by this byte.
    if (found > 0) begin
      res = pending_frames.pop_back();
      res.last_frame = 1'b1;
      pending_frames.push_back(res);
    end
  endfunction

  // Offer one byte, hold it until accepted, then run it through the predictor.
  // valid stays high on return so back-to-back items need no second drive.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  // Build one frame with the current markers and send it. A nonzero cut
  // sends only that many leading bytes.
  task automatic send_frame(input logic [7:0] ftype, input int len, input bit good_end,
                            input int cut);
    logic [7:0] frame_bytes[$];
    int         i;
    frame_bytes.push_back(start_mark);
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(len[7:0]);
    for (i = 0; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(good_end ? end_mark : end_mark ^ 8'($urandom_range(1, 255)));
    if (cut > 0 && cut < frame_bytes.size()) frame_bytes = frame_bytes[0:cut - 1];
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
  endtask

  // Drop valid, wait until the block is back in idle and every expected
  // result has been taken, then wait out the settle margin.
  task automatic settle_block();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_START_MARKER: start_mark = val;
      REG_END_MARKER:   end_mark   = val;
      default: ;
    endcase
    regs_written++;
    @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest are frames with
  // a bad closing byte, cut-off frames and loose noise bytes.
  task automatic send_random_traffic(input int n_bytes);
    int         goal;
    int         r;
    int         len;
    logic [7:0] ftype;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      case ($urandom_range(0, 3))
        0:       ftype = TYPE_CYCLE_TIME;
        1:       ftype = TYPE_PARTS_COUNT;
        default: ftype = 8'($urandom_range(0, 255));
      endcase
      r = $urandom_range(0, 19);
      if (r < 14)      len = $urandom_range(0, 7);
      else if (r < 19) len = $urandom_range(8, 24);
      else             len = $urandom_range(25, 40);
      r = $urandom_range(0, 99);
      if (r < 78)      send_frame(ftype, len, 1'b1, 0);
      else if (r < 86) send_frame(ftype, len, 1'b0, 0);
      else if (r < 92) send_frame(ftype, len, 1'b1, $urandom_range(1, len + 3));
      else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Hand-picked bytes at the reset markers: leading junk, the most negative
  // value, a zero-length frame that waits for a fifth byte, a short payload of
  // unknown type, a wrong closing byte and a window with no start marker.
  task automatic test_directed();
    logic [7:0] seq [28];
    seq = '{8'h00, 8'hFF,
            START_MARKER_RST, TYPE_CYCLE_TIME, 8'd4, 8'h80, 8'h00, 8'h00, 8'h00,
            END_MARKER_RST,
            START_MARKER_RST, TYPE_PARTS_COUNT, 8'd0, END_MARKER_RST, 8'h13,
            START_MARKER_RST, 8'hFF, 8'd3, 8'h11, 8'h22, 8'h33, END_MARKER_RST,
            START_MARKER_RST, 8'h00, 8'd0, 8'h54, 8'h7F,
            8'h01};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // A header whose length spans the frames behind it blocks the store while
  // zero-length frames pile up; its closing byte is wrong, so the last byte
  // releases every one of them at once.
  task automatic test_result_burst();
    int k;
    send_byte(start_mark);
    for (k = 0; k < BURST_FRAMES; k++) begin
      send_byte(start_mark);
      // The first inner type byte doubles as the blocking header's length.
      send_byte(k == 0 ? BURST_HDR_LEN : (k % 3 == 0) ? TYPE_CYCLE_TIME :
                (k % 3 == 1) ? TYPE_PARTS_COUNT : 8'($urandom_range(3, 255)));
      send_byte(8'd0);
      send_byte(end_mark);
    end
    send_byte(start_mark ^ 8'h01);
    send_byte(end_mark ^ 8'h01);
  endtask

  // Hold the receiver off while the source keeps offering complete frames,
  // so the output register and the pending result fill and rx stalls.
  task automatic test_backpressure();
    src_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (6) send_frame(8'($urandom_range(0, 255)), $urandom_range(0, 7), 1'b1, 0);
    src_gaps = 1'b1;
  endtask

  // Sweep the markers through their extremes, equal markers and back to reset
  // values; also write two indexes that must be ignored.
  task automatic test_marker_settings();
    logic [7:0] starts [4];
    logic [7:0] ends [4];
    int         i;
    starts = '{8'h00, 8'hFF, 8'h5A, START_MARKER_RST};
    ends   = '{8'hFF, 8'h00, 8'h5A, END_MARKER_RST};
    for (i = 0; i < 4; i++) begin
      settle_block();
      write_reg(REG_START_MARKER, starts[i]);
      write_reg(REG_END_MARKER, ends[i]);
      if (i == 1) begin
        write_reg(REG_SPARE, 8'h3C);
        write_reg(REG_TOP, 8'hFF);
      end
      // Alternate stretches with and without idling on either side.
      src_gaps  = (i % 2 == 0);
      sink_gaps = (i != 2);
      send_random_traffic(20);
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  task automatic flag_field(input string field, input logic signed [63:0] want_v,
                            input logic signed [63:0] got_v);
    $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
    errors++;
  endtask

  // Receiver ready: random drops, and one long hold-off on request, counted here.
  initial begin : drive_frame_ready
    int stall;
    frame_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else if (sink_gaps) begin
        stall = pick_gap();
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation, field by field.
  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected frame result: type %0d length %0d value %0d",
               frame_ch.frame_type, frame_ch.payload_length, frame_ch.frame_value);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (frame_ch.frame_type !== want.frame_type)
          flag_field("frame_type", want.frame_type, frame_ch.frame_type);
        if (frame_ch.frame_class !== want.frame_class)
          flag_field("frame_class", want.frame_class, frame_ch.frame_class);
        if (frame_ch.frame_value !== want.frame_value)
          flag_field("frame_value", $signed(want.frame_value), frame_ch.frame_value);
        if (frame_ch.payload_length !== want.payload_length)
          flag_field("payload_length", want.payload_length, frame_ch.payload_length);
        if (frame_ch.short_payload !== want.short_payload)
          flag_field("short_payload", want.short_payload, frame_ch.short_payload);
        if (frame_ch.last_frame !== want.last_frame)
          flag_field("last_frame", want.last_frame, frame_ch.last_frame);
      end
    end
  end

  // Hang detector: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Known values on every input from time zero; reset markers in the predictor.
    rst             = 1'b1;
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = 8'h00;
    cfg_ch.data     = 8'h00;
    start_mark      = START_MARKER_RST;
    end_mark        = END_MARKER_RST;
    src_gaps        = 1'b1;
    sink_gaps       = 1'b1;
    hold_req        = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_result_burst();
    test_backpressure();
    send_random_traffic(20);
    test_marker_settings();
    settle_block();

    if (pending_frames.size() != 0) begin
      $error("%0d expected frame results never arrived", pending_frames.size());
      errors++;
    end
    $display("run: %0d bytes in, %0d frame results checked, %0d register writes",
             bytes_sent, frames_checked, regs_written);
    $display("run: corner frames, a burst of results from one byte, marker sweep, long stall");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mlpd_pkg.sv
hw/rtl/mlpd_if.sv
hw/rtl/mlpd_datapath.sv
hw/rtl/mlpd_ctrl.sv
hw/rtl/marker_length_packet_deframer_top.sv
tb/tb.sv
